FILE: rtl/core/lset_pkg.sv
package lset_pkg;

	localparam int SENSORS    = 6;
	localparam int LEVEL_W    = 3;
	localparam int CONF_CNT_W = 4;
	localparam int HOLD_CNT_W = 8;
	localparam int ERR_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;

	typedef logic [SENSORS-1:0]    mask_t;
	typedef logic [LEVEL_W-1:0]    level_t;
	typedef logic [CONF_CNT_W-1:0] conf_cnt_t;
	typedef logic [HOLD_CNT_W-1:0] hold_cnt_t;
	typedef logic signed [ERR_W-1:0] err_t;

	// curve hint codes
	localparam logic [1:0] HINT_NONE  = 2'd0;
	localparam logic [1:0] HINT_LEFT  = 2'd1;
	localparam logic [1:0] HINT_RIGHT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_INNER   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INNER  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_BLEND   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BLEND  = 4'd7;

	localparam mask_t CENTER_BITS = 6'h0C;
	localparam mask_t LEFT_EDGE   = 6'h03;
	localparam mask_t RIGHT_EDGE  = 6'h30;

	// sensor weights, plain and in Q.8
	localparam logic signed [4:0] WEIGHT [0:SENSORS-1] = '{-5'sd5, -5'sd3, -5'sd1,
		5'sd1, 5'sd3, 5'sd5};
	localparam err_t WEIGHT_Q8 [0:SENSORS-1] = '{-12'sd1280, -12'sd768, -12'sd256,
		12'sd256, 12'sd768, 12'sd1280};

	// divider: |sum| * 256 over the dot count
	localparam int DIVIDEND_W    = 12;
	localparam int DIVISOR_W     = 3;
	localparam int BITS_PER_STEP = 3;
	localparam int DIV_STEPS     = DIVIDEND_W / BITS_PER_STEP;
	localparam int DIV_STEP_W    = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_res_t;

	function automatic mask_t center_group(input mask_t m);
		mask_t r;
		r = m & CENTER_BITS;
		if (r == CENTER_BITS) begin
			return CENTER_BITS;
		end
		if (m[2] && m[1]) begin
			r[1] = 1'b1;
			if (m[0]) r[0] = 1'b1;
		end
		if (m[3] && m[4]) begin
			r[4] = 1'b1;
			if (m[5]) r[5] = 1'b1;
		end
		return r;
	endfunction

	// true when the mask holds two or more runs of set bits
	function automatic logic multi_group(input mask_t m);
		logic [2:0] groups;
		groups = 3'd0;
		for (int i = 0; i < SENSORS; i++) begin
			if (m[i] && (i == 0 || !m[(i == 0) ? 0 : i-1])) begin
				groups = groups + 3'd1;
			end
		end
		return groups >= 3'd2;
	endfunction

endpackage

FILE: rtl/core/lset_lane.sv
module lset_lane #(
	parameter int LEVEL_MAX = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    update,
	input  logic                    raw_bit,
	input  logic [lset_pkg::LEVEL_W-1:0] on_level,
	input  logic [lset_pkg::LEVEL_W-1:0] off_level,
	input  logic                    stable_bit,
	output logic                    cand_bit
);
	import lset_pkg::*;

	level_t level_q;

	// saturating up/down sensor level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (update) begin
			if (raw_bit) begin
				if (level_q < level_t'(LEVEL_MAX)) level_q <= level_q + level_t'(1);
			end else if (level_q != '0) begin
				level_q <= level_q - level_t'(1);
			end
		end
	end

	// on test wins over off test; neither keeps the stable bit
	always_comb begin
		if (level_q >= on_level) cand_bit = 1'b1;
		else if (level_q <= off_level) cand_bit = 1'b0;
		else cand_bit = stable_bit;
	end

endmodule

FILE: rtl/core/lset_div.sv
module lset_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lset_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [lset_pkg::DIVISOR_W-1:0]  divisor,
	output lset_pkg::div_res_t              res
);
	import lset_pkg::*;

	logic [DIVISOR_W:0]    rem_q, rem_n;
	logic [DIVIDEND_W-1:0] quo_q, quo_n;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  busy_q, done_q;

	// restoring division, BITS_PER_STEP quotient bits per cycle while busy
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			rem_n = {rem_n[DIVISOR_W-1:0], quo_n[DIVIDEND_W-1]};
			quo_n = {quo_n[DIVIDEND_W-2:0], 1'b0};
			if (rem_n >= {1'b0, den_q}) begin
				rem_n = rem_n - {1'b0, den_q};
				quo_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= DIV_STEP_W'(DIV_STEPS);
		end else if (busy_q) begin
			step_q <= step_q - DIV_STEP_W'(1);
			if (step_q == DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

FILE: rtl/core/line_sensor_error_tracker.sv
// Line sensor error tracker: one voted 6-bit sensor sample in, one position result out.
// Steps: accept, filter, normalize, tally, the divider for the mean weight, then finish; the
// finish step waits while m_tready holds back the previous result. Samples are taken one at a
// time: the next is accepted only in idle, once the previous one has left the finish step.
// A new sample is taken while the previous result still waits on the output register.
// Reset (arst_n low, asynchronous) clears levels, masks, countdowns, error, search = right.
module line_sensor_error_tracker #(
	parameter int LEVEL_MAX       = 3,
	parameter int CONFIRM_SAMPLES = 2,
	parameter int CURVE_HOLD      = 10,
	parameter int CENTER_HOLD     = 5,
	parameter int LOST_HOLD       = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample [5:0], zero [7:6]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// error [11:0], used_mask [17:12], filt_mask [23:18], dot_count [26:24],
	// lost [27], hold [28], hint [30:29], uncertain [31],
	// split [32], wide [33], search_right [34], zero [39:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [lset_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lset_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lset_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILT = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;

	// configuration registers
	level_t      on_lvl_q, off_lvl_q;
	logic [10:0] hold_lim_q;
	logic [11:0] jump_lim_q;
	mask_t       l_inner_q, r_inner_q, l_blend_q, r_blend_q;

	// tracker state
	mask_t     confirmed_q, pending_q;
	conf_cnt_t conf_cnt_q;
	hold_cnt_t center_cd_q, left_cd_q, right_cd_q, lost_cnt_q;
	err_t      prev_err_q;
	logic      search_q;

	// per-sample working registers
	mask_t      raw_q, filt_q, used_q;
	logic       hold_q, unc_q;
	logic [1:0] hint_q;
	logic [2:0] cnt_s2;
	logic       spl_s2, wid_s2, neg_s2;
	err_t       best_err_s2;

	// output register
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	logic accept, out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// ---------------------------------------------------------------------------------
	// Sensor lanes: each keeps its own level and offers a candidate bit
	// ---------------------------------------------------------------------------------
	mask_t cand;

	for (genvar g = 0; g < SENSORS; g++) begin : g_lane
		lset_lane #(
			.LEVEL_MAX(LEVEL_MAX)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.update    (accept),
			.raw_bit   (s_tdata[g]),
			.on_level  (on_lvl_q),
			.off_level (off_lvl_q),
			.stable_bit(confirmed_q[g]),
			.cand_bit  (cand[g])
		);
	end

	// ---------------------------------------------------------------------------------
	// Merge: confirm the candidate over several samples
	// ---------------------------------------------------------------------------------
	mask_t     pend_n, conf_n;
	conf_cnt_t ccnt_n;

	always_comb begin
		pend_n = pending_q;
		ccnt_n = conf_cnt_q;
		conf_n = confirmed_q;
		if (cand == confirmed_q) begin
			pend_n = confirmed_q;
			ccnt_n = conf_cnt_t'(CONFIRM_SAMPLES);
		end else begin
			if (cand != pending_q) begin
				pend_n = cand;
				ccnt_n = conf_cnt_t'(1);
			end else if (conf_cnt_q < conf_cnt_t'(CONFIRM_SAMPLES)) begin
				ccnt_n = conf_cnt_q + conf_cnt_t'(1);
			end
			if (ccnt_n >= conf_cnt_t'(CONFIRM_SAMPLES)) begin
				conf_n = pend_n;
				ccnt_n = conf_cnt_t'(CONFIRM_SAMPLES);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Normalize: hint and center countdowns, then pick the mask to use
	// ---------------------------------------------------------------------------------
	mask_t            seen, used_n;
	hold_cnt_t        left_n, right_n, center_n;
	logic [1:0]       hint_n;
	logic             hold_n, unc_n;
	logic signed [12:0] lim13, prev13, abs_prev13;

	always_comb begin
		seen = filt_q | raw_q;

		if ((seen & l_inner_q) != '0) left_n = hold_cnt_t'(CURVE_HOLD);
		else if (left_cd_q != '0) left_n = left_cd_q - hold_cnt_t'(1);
		else left_n = left_cd_q;

		if ((seen & r_inner_q) != '0) right_n = hold_cnt_t'(CURVE_HOLD);
		else if (right_cd_q != '0) right_n = right_cd_q - hold_cnt_t'(1);
		else right_n = right_cd_q;

		if ((seen & CENTER_BITS) != '0) center_n = hold_cnt_t'(CENTER_HOLD);
		else if (center_cd_q != '0) center_n = center_cd_q - hold_cnt_t'(1);
		else center_n = center_cd_q;

		if (left_n != '0 && right_n == '0) hint_n = HINT_LEFT;
		else if (right_n != '0 && left_n == '0) hint_n = HINT_RIGHT;
		else hint_n = HINT_NONE;

		lim13      = signed'({2'b00, hold_lim_q});
		prev13     = {prev_err_q[ERR_W-1], prev_err_q};
		abs_prev13 = prev13[12] ? -prev13 : prev13;

		hold_n = 1'b0;
		unc_n  = 1'b0;
		if ((filt_q & CENTER_BITS) != '0) begin
			used_n = center_group(filt_q);
			hold_n = (used_n != filt_q);
		end else if (filt_q != '0) begin
			used_n = filt_q;
			unc_n  = multi_group(filt_q);
		end else if (hint_n == HINT_LEFT && prev13 <= lim13) begin
			hold_n = 1'b1;
			used_n = l_blend_q;
		end else if (hint_n == HINT_RIGHT && prev13 >= -lim13) begin
			hold_n = 1'b1;
			used_n = r_blend_q;
		end else if (center_n != '0 &&
			(abs_prev13 <= lim13 || (raw_q & CENTER_BITS) != '0)) begin
			hold_n = 1'b1;
			used_n = CENTER_BITS;
		end else begin
			used_n = '0;
		end
	end

	// ---------------------------------------------------------------------------------
	// Tally: dot count, weight sum, group shape, nearest weight for a split mask
	// ---------------------------------------------------------------------------------
	logic [2:0]         cnt_n;
	logic signed [4:0]  sum_n;
	logic [3:0]         abs_sum;
	logic signed [13:0] wdiff;
	logic [12:0]        best_d;
	err_t               best_err_n;

	always_comb begin
		cnt_n      = '0;
		sum_n      = '0;
		best_d     = 13'h1FFF;
		best_err_n = '0;
		wdiff      = '0;
		for (int i = 0; i < SENSORS; i++) begin
			if (used_q[i]) begin
				cnt_n = cnt_n + 3'd1;
				sum_n = sum_n + WEIGHT[i];
				wdiff = 14'(WEIGHT_Q8[i]) - 14'(prev_err_q);
				if (wdiff[13]) wdiff = -wdiff;
				if (wdiff[12:0] < best_d) begin
					best_d     = wdiff[12:0];
					best_err_n = WEIGHT_Q8[i];
				end
			end
		end
		abs_sum = sum_n[4] ? 4'(-sum_n) : sum_n[3:0];
	end

	div_res_t div_res;

	lset_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_CALC),
		.dividend({abs_sum, 8'h00}),
		.divisor (cnt_n),
		.res     (div_res)
	);

	// ---------------------------------------------------------------------------------
	// Finish: error, jump guard, search direction, lost hold
	// ---------------------------------------------------------------------------------
	err_t               err_n;
	logic signed [13:0] diff14;
	logic [12:0]        abs_diff;
	logic               unc_f, search_n, lost_n;
	hold_cnt_t          lost_cnt_n;
	mask_t              sm;

	always_comb begin
		search_n   = search_q;
		unc_f      = unc_q;
		lost_n     = 1'b0;
		lost_cnt_n = '0;
		sm         = used_q | raw_q;
		diff14     = '0;
		abs_diff   = '0;
		if (cnt_s2 == '0) begin
			err_n = prev_err_q;
			lost_cnt_n = (lost_cnt_q < hold_cnt_t'(LOST_HOLD)) ?
				lost_cnt_q + hold_cnt_t'(1) : lost_cnt_q;
			lost_n = (lost_cnt_n >= hold_cnt_t'(LOST_HOLD));
		end else begin
			if (spl_s2) err_n = best_err_s2;
			else if (neg_s2) err_n = -err_t'(div_res.quotient);
			else err_n = err_t'(div_res.quotient);

			diff14   = 14'(err_n) - 14'(prev_err_q);
			abs_diff = diff14[13] ? 13'(-diff14) : diff14[12:0];
			if (abs_prev13 <= lim13 && abs_diff >= {1'b0, jump_lim_q}) unc_f = 1'b1;

			if (err_n > 12'sd128) search_n = 1'b1;
			else if (err_n < -12'sd512) search_n = 1'b0;
			else if ((sm & RIGHT_EDGE) != '0 && (sm & LEFT_EDGE) == '0) search_n = 1'b1;
			else if ((sm & LEFT_EDGE) != '0 && (sm & RIGHT_EDGE) == '0) search_n = 1'b0;
		end
	end

	// ---------------------------------------------------------------------------------
	// Sequencer and state registers
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			on_lvl_q    <= level_t'(2);
			off_lvl_q   <= level_t'(1);
			hold_lim_q  <= 11'd256;
			jump_lim_q  <= 12'd768;
			l_inner_q   <= 6'd2;
			r_inner_q   <= 6'd16;
			l_blend_q   <= 6'd6;
			r_blend_q   <= 6'd24;
			confirmed_q <= '0;
			pending_q   <= '0;
			conf_cnt_q  <= '0;
			center_cd_q <= '0;
			left_cd_q   <= '0;
			right_cd_q  <= '0;
			lost_cnt_q  <= '0;
			prev_err_q  <= '0;
			search_q    <= 1'b1;
			m_tvalid_q  <= 1'b0;
		end else begin
			// apply configuration writes at once; unknown indexes drop
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ON_LEVEL:    on_lvl_q   <= cfg_data[LEVEL_W-1:0];
					REG_OFF_LEVEL:   off_lvl_q  <= cfg_data[LEVEL_W-1:0];
					REG_HOLD_LIMIT:  hold_lim_q <= cfg_data[10:0];
					REG_JUMP_LIMIT:  jump_lim_q <= cfg_data[11:0];
					REG_LEFT_INNER:  l_inner_q  <= cfg_data[SENSORS-1:0];
					REG_RIGHT_INNER: r_inner_q  <= cfg_data[SENSORS-1:0];
					REG_LEFT_BLEND:  l_blend_q  <= cfg_data[SENSORS-1:0];
					REG_RIGHT_BLEND: r_blend_q  <= cfg_data[SENSORS-1:0];
					default: ;
				endcase
			end

			// drop the output once taken, unless the finish step refills it
			if (m_tvalid_q && m_tready && state_q != ST_FIN) m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_FILT;
				end
				ST_FILT: begin
					// advance the confirm stage
					confirmed_q <= conf_n;
					pending_q   <= pend_n;
					conf_cnt_q  <= ccnt_n;
					state_q     <= ST_NORM;
				end
				ST_NORM: begin
					left_cd_q   <= left_n;
					right_cd_q  <= right_n;
					center_cd_q <= center_n;
					state_q     <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold here until the output register frees up
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						lost_cnt_q <= lost_cnt_n;
						search_q   <= search_n;
						prev_err_q <= err_n;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) raw_q <= s_tdata[SENSORS-1:0];
		if (state_q == ST_FILT) filt_q <= conf_n;
		if (state_q == ST_NORM) begin
			used_q <= used_n;
			hold_q <= hold_n;
			unc_q  <= unc_n;
			hint_q <= hint_n;
		end
		if (state_q == ST_CALC) begin
			cnt_s2      <= cnt_n;
			spl_s2      <= (cnt_n != '0) && multi_group(used_q);
			wid_s2      <= (cnt_n >= 3'd4);
			neg_s2      <= sum_n[4];
			best_err_s2 <= best_err_n;
		end
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= {5'b0, search_n, wid_s2, spl_s2, unc_f, hint_q, hold_q, lost_n,
				cnt_s2, filt_q, used_q, err_n};
		end
	end

	// ---------------------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------------------
	a_conf_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		conf_cnt_q <= conf_cnt_t'(CONFIRM_SAMPLES))
		else $error("confirm counter beyond its limit");

	a_lost_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lost_cnt_q <= hold_cnt_t'(LOST_HOLD))
		else $error("lost counter beyond its limit");

	a_fin_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("finished sample did not reach the output register");

	a_lost_no_dots: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27]) |-> (m_tdata[26:24] == 3'd0))
		else $error("line lost reported with dots in the used mask");

endmodule

FILE: tb/tb_top.sv
module tb_top;
	import lset_pkg::*;

	// Block parameters, passed to the instance so the predictor shares them
	localparam int LEVEL_MAX       = 3;
	localparam int CONFIRM_SAMPLES = 2;
	localparam int CURVE_HOLD      = 10;
	localparam int CENTER_HOLD     = 5;
	localparam int LOST_HOLD       = 5;

	// Longest stretch without any transaction before the run is declared hung
	localparam int QUIET_LIMIT  = 2000;
	// Hold-off after the last result before a register write or the verdict
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES  = 24;
	localparam int SPLIT_NONE    = 25600;

	// Result word as it sits on m_tdata, highest field first
	typedef struct packed {
		logic [4:0] pad;
		logic       search_right;
		logic       wide;
		logic       split;
		logic       uncertain;
		logic [1:0] hint_code;
		logic       hold_flag;
		logic       lost_flag;
		logic [2:0] dot_count;
		mask_t      filt_mask;
		mask_t      used_mask;
		err_t       error;
	} track_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // sample [5:0], zero [7:6]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // error, used, stable, dots, lost, hold, hint, unc, split...
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	line_sensor_error_tracker #(
		.LEVEL_MAX      (LEVEL_MAX),
		.CONFIRM_SAMPLES(CONFIRM_SAMPLES),
		.CURVE_HOLD     (CURVE_HOLD),
		.CENTER_HOLD    (CENTER_HOLD),
		.LOST_HOLD      (LOST_HOLD)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Tracker shadow: filter levels, confirm logic, countdowns, last error
	// ------------------------------------------------------------------
	level_t lvl [SENSORS];
	mask_t  conf_m, pend_m;
	int     conf_cnt, center_cd, left_cd, right_cd, lost_cnt, prev_err;
	logic   search_r;

	// Shadow of the register file
	int     on_lvl, off_lvl, hold_lim, jump_lim;
	mask_t  left_inner, right_inner, left_blend, right_blend;

	track_result_t pending_results [$];
	track_result_t check_want, check_got;
	int   mismatch_cnt = 0;
	int   quiet_cycles = 0;
	bit   idle_on      = 1'b1;
	int   ready_hold   = 0;

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// A run of set bits starts wherever a bit is set and the one below is clear
	function automatic int runs(input mask_t m);
		return $countones(m & ~{m[SENSORS-2:0], 1'b0});
	endfunction

	// Keep the center pair and whatever touches it from the center outward
	function automatic mask_t keep_center(input mask_t m);
		mask_t r;
		r = m & CENTER_BITS;
		if (r != CENTER_BITS) begin
			if (m[2] && m[1]) r[1:0] = {1'b1, m[0]};
			if (m[3] && m[4]) r[5:4] = {m[5], 1'b1};
		end
		return r;
	endfunction

	function automatic void tracker_reset();
		for (int i = 0; i < SENSORS; i++) lvl[i] = '0;
		conf_m = '0; pend_m = '0; conf_cnt = 0;
		center_cd = 0; left_cd = 0; right_cd = 0;
		lost_cnt = 0; prev_err = 0; search_r = 1'b1;
		on_lvl = 2; off_lvl = 1; hold_lim = 256; jump_lim = 768;
		left_inner = 6'h02; right_inner = 6'h10;
		left_blend = 6'h06; right_blend = 6'h18;
	endfunction

	function automatic void tracker_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_ON_LEVEL:    on_lvl      = val[2:0];
			REG_OFF_LEVEL:   off_lvl     = val[2:0];
			REG_HOLD_LIMIT:  hold_lim    = val[10:0];
			REG_JUMP_LIMIT:  jump_lim    = val[11:0];
			REG_LEFT_INNER:  left_inner  = val[5:0];
			REG_RIGHT_INNER: right_inner = val[5:0];
			REG_LEFT_BLEND:  left_blend  = val[5:0];
			REG_RIGHT_BLEND: right_blend = val[5:0];
			default: ;
		endcase
	endfunction

	// Advance the shadow by one sample and return the result it must produce
	function automatic track_result_t track_sample(input mask_t raw);
		track_result_t r;
		mask_t      cand, filt, seen, used, edge_seen;
		logic [1:0] hint;
		logic       hold, unc, lost;
		int         sum, cnt, err, best_d, best_w, d, w;

		// Saturating levels, then on/off thresholds; on wins when both hit
		cand = conf_m;
		for (int i = 0; i < SENSORS; i++) begin
			if (raw[i]) begin
				if (lvl[i] < LEVEL_MAX) lvl[i] = lvl[i] + 1'b1;
			end else if (lvl[i] != 0) begin
				lvl[i] = lvl[i] - 1'b1;
			end
			if (lvl[i] >= on_lvl) cand[i] = 1'b1;
			else if (lvl[i] <= off_lvl) cand[i] = 1'b0;
		end

		// Confirm a new candidate only after it repeats
		if (cand == conf_m) begin
			pend_m = conf_m;
			conf_cnt = CONFIRM_SAMPLES;
		end else begin
			if (cand != pend_m) begin
				pend_m = cand;
				conf_cnt = 1;
			end else if (conf_cnt < CONFIRM_SAMPLES) begin
				conf_cnt++;
			end
			if (conf_cnt >= CONFIRM_SAMPLES) begin
				conf_m = pend_m;
				conf_cnt = CONFIRM_SAMPLES;
			end
		end
		filt = conf_m;
		seen = filt | raw;

		// Curve hint countdowns; a hint counts only when the other side is quiet
		if (|(seen & left_inner)) left_cd = CURVE_HOLD;
		else if (left_cd > 0) left_cd--;
		if (|(seen & right_inner)) right_cd = CURVE_HOLD;
		else if (right_cd > 0) right_cd--;
		if (left_cd > 0 && right_cd == 0) hint = HINT_LEFT;
		else if (right_cd > 0 && left_cd == 0) hint = HINT_RIGHT;
		else hint = HINT_NONE;

		if (|(seen & CENTER_BITS)) center_cd = CENTER_HOLD;
		else if (center_cd > 0) center_cd--;

		// Normalize: trim to the center group, or bridge a gap with a blend mask
		hold = 1'b0;
		unc  = 1'b0;
		lost = 1'b0;
		if (|(filt & CENTER_BITS)) begin
			used = keep_center(filt);
			hold = (used != filt);
		end else if (filt != '0) begin
			used = filt;
			unc  = (runs(filt) >= 2);
		end else if (hint == HINT_LEFT && prev_err <= hold_lim) begin
			hold = 1'b1;
			used = left_blend;
		end else if (hint == HINT_RIGHT && prev_err >= -hold_lim) begin
			hold = 1'b1;
			used = right_blend;
		end else if (center_cd > 0 && (mag(prev_err) <= hold_lim || |(raw & CENTER_BITS))) begin
			hold = 1'b1;
			used = CENTER_BITS;
		end else begin
			used = '0;
		end

		sum = 0;
		cnt = 0;
		for (int i = 0; i < SENSORS; i++) begin
			if (used[i]) begin
				sum += 2 * i - 5;
				cnt++;
			end
		end

		r = '0;
		if (cnt == 0) begin
			// No line: hold the last error and count toward lost
			if (lost_cnt < LOST_HOLD) lost_cnt++;
			lost = (lost_cnt >= LOST_HOLD);
			err  = prev_err;
		end else begin
			lost_cnt = 0;
			r.split  = (runs(used) >= 2);
			r.wide   = (cnt >= 4);
			if (r.split) begin
				// Follow the weight closest to where the line was
				best_d = SPLIT_NONE;
				best_w = 0;
				for (int i = 0; i < SENSORS; i++) begin
					if (used[i]) begin
						w = (2 * i - 5) * 256;
						d = mag(w - prev_err);
						if (d < best_d) begin
							best_d = d;
							best_w = w;
						end
					end
				end
				err = best_w;
			end else begin
				err = (sum * 256) / cnt;
			end
			if (mag(prev_err) <= hold_lim && mag(err - prev_err) >= jump_lim) unc = 1'b1;
			if (err > 128) begin
				search_r = 1'b1;
			end else if (err < -512) begin
				search_r = 1'b0;
			end else begin
				edge_seen = used | raw;
				if (|(edge_seen & RIGHT_EDGE) && !(|(edge_seen & LEFT_EDGE))) search_r = 1'b1;
				else if (|(edge_seen & LEFT_EDGE) && !(|(edge_seen & RIGHT_EDGE))) search_r = 1'b0;
			end
			prev_err = err;
		end

		r.error        = err[ERR_W-1:0];
		r.used_mask    = used;
		r.filt_mask    = filt;
		r.dot_count    = cnt[2:0];
		r.lost_flag    = lost;
		r.hold_flag    = hold;
		r.hint_code    = hint;
		r.uncertain    = unc;
		r.search_right = search_r;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Idle pattern: mostly back-to-back or short gaps, a few long ones
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Output side: drop tready for a random stretch now and then
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (idle_on && m_tready && $urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			ready_hold <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offer one sample; tvalid stays high on return so the next call can
	// chain without dropping it. Predict at the accepting edge.
	task automatic send_mask(input mask_t m);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, m};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(track_sample(m));
	endtask

	// Drop tvalid, hold until every predicted result is out, then let the
	// pipeline go quiet
	task automatic quiesce();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker_write(idx, val[CFG_DATA_W-1:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input int on_v, input int off_v, input int hold_v,
			input int jump_v, input int li, input int ri, input int lb, input int rb);
		quiesce();
		write_reg(REG_ON_LEVEL,    on_v);
		write_reg(REG_OFF_LEVEL,   off_v);
		write_reg(REG_HOLD_LIMIT,  hold_v);
		write_reg(REG_JUMP_LIMIT,  jump_v);
		write_reg(REG_LEFT_INNER,  li);
		write_reg(REG_RIGHT_INNER, ri);
		write_reg(REG_LEFT_BLEND,  lb);
		write_reg(REG_RIGHT_BLEND, rb);
	endtask

	// Line-like stimulus: a drifting group held for a few samples, plus gaps
	// long enough to reach lost, splits, wide bars and pure noise
	task automatic run_tracks(input int n);
		int    sent, hold, pos, width, r;
		bit    noisy;
		mask_t m;
		sent = 0;
		pos  = $urandom_range(0, 5);
		while (sent < n) begin
			r     = $urandom_range(0, 99);
			hold  = $urandom_range(1, 6);
			noisy = 1'b0;
			if (r < 55) begin
				width = $urandom_range(1, 3);
				m     = mask_t'(((1 << width) - 1) << pos);
				pos   = pos + int'($urandom_range(0, 2)) - 1;
				if (pos < 0) pos = 0;
				if (pos > SENSORS - 1) pos = SENSORS - 1;
			end else if (r < 70) begin
				m    = '0;
				hold = $urandom_range(1, 12);
			end else if (r < 80) begin
				do m = mask_t'($urandom); while (runs(m) < 2);
				hold = $urandom_range(2, 4);
			end else if (r < 88) begin
				width = $urandom_range(4, 6);
				m     = mask_t'(((1 << width) - 1) << $urandom_range(0, SENSORS - width));
			end else begin
				noisy = 1'b1;
				hold  = $urandom_range(1, 3);
			end
			if ($urandom_range(0, 24) == 0) idle_on = ~idle_on;
			for (int k = 0; k < hold && sent < n; k++) begin
				send_mask(noisy ? mask_t'($urandom) : m);
				sent++;
			end
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset values: full bar, center, trimmed bar, split, a gap long enough
	// for blend, center hold and lost, then each edge pair
	task automatic test_directed_track();
		mask_t seq [$];
		seq = '{6'h3F, 6'h3F, 6'h3F, 6'h0C, 6'h0C, 6'h0C, 6'h1E, 6'h1E,
			6'h21, 6'h21, 6'h21, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
			6'h00, 6'h00, 6'h00, 6'h30, 6'h30, 6'h30, 6'h03, 6'h03, 6'h03};
		foreach (seq[i]) send_mask(seq[i]);
		quiesce();
	endtask

	// Threshold and limit corners, overlapping on/off levels included
	task automatic test_threshold_corners();
		apply_config(2, 1, 256, 768, 6'h02, 6'h10, 6'h06, 6'h18);
		run_tracks(130);
		apply_config(3, 0, 1280, 2560, 6'h03, 6'h30, 6'h07, 6'h38);
		run_tracks(130);
		apply_config(1, 2, 0, 0, 6'h3F, 6'h3F, 6'h3F, 6'h3F);
		run_tracks(130);
		apply_config(0, 0, 2047, 4095, 6'h00, 6'h00, 6'h00, 6'h00);
		run_tracks(130);
		apply_config(7, 7, 128, 256, 6'h01, 6'h20, 6'h21, 6'h0C);
		run_tracks(40);
		apply_config(3, 2, 640, 1024, 6'h06, 6'h18, 6'h02, 6'h10);
		run_tracks(130);
		apply_config(1, 1, 512, 512, 6'h0C, 6'h0C, 6'h00, 6'h3F);
		run_tracks(130);
		quiesce();
	endtask

	// Full-width random register values; writes past the list must be ignored
	task automatic test_register_extremes();
		for (int p = 0; p < 4; p++) begin
			apply_config($urandom_range(0, 7), $urandom_range(0, 7),
				$urandom_range(0, 2047), $urandom_range(0, 4095),
				$urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 63));
			write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom_range(0, 4095));
			run_tracks(120);
		end
		quiesce();
		write_reg(CFG_IDX_W'(15), 4095);
	endtask

	// Reset configuration with pauses where the sender waits out the pipe
	task automatic test_track_random();
		apply_config(2, 1, 256, 768, 6'h02, 6'h10, 6'h06, 6'h18);
		run_tracks(220);
		quiesce();
		run_tracks(230);
		quiesce();
	endtask

	// No idling on either side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int i = 0; i < 150; i++) send_mask(mask_t'($urandom));
		quiesce();
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input bit differs,
			input int want_v, input int got_v);
		if (differs) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want_v, got_v);
		end
	endtask

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) $display("result with nothing pending: %h", m_tdata);
			end else begin
				check_want = pending_results.pop_front();
				check_got  = m_tdata;
				check_field("error", check_want.error !== check_got.error,
					int'(check_want.error), int'(check_got.error));
				check_field("used_mask", check_want.used_mask !== check_got.used_mask,
					check_want.used_mask, check_got.used_mask);
				check_field("filt_mask", check_want.filt_mask !== check_got.filt_mask,
					check_want.filt_mask, check_got.filt_mask);
				check_field("dot_count", check_want.dot_count !== check_got.dot_count,
					check_want.dot_count, check_got.dot_count);
				check_field("lost_flag", check_want.lost_flag !== check_got.lost_flag,
					check_want.lost_flag, check_got.lost_flag);
				check_field("hold_flag", check_want.hold_flag !== check_got.hold_flag,
					check_want.hold_flag, check_got.hold_flag);
				check_field("hint_code", check_want.hint_code !== check_got.hint_code,
					check_want.hint_code, check_got.hint_code);
				check_field("uncertain", check_want.uncertain !== check_got.uncertain,
					check_want.uncertain, check_got.uncertain);
				check_field("split", check_want.split !== check_got.split,
					check_want.split, check_got.split);
				check_field("wide", check_want.wide !== check_got.wide,
					check_want.wide, check_got.wide);
				check_field("search_right", check_want.search_right !== check_got.search_right,
					check_want.search_right, check_got.search_right);
				check_field("padding", check_want.pad !== check_got.pad,
					check_want.pad, check_got.pad);
			end
		end
	end

	// Watchdog: count cycles in which no transaction moves on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("line_sensor_error_tracker verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		tracker_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_track();
		test_threshold_corners();
		test_register_extremes();
		test_track_random();
		test_back_to_back();

		// Wait out the pipe and give any stray result time to show up
		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0) begin
			$display("line_sensor_error_tracker verification clean");
		end else begin
			$display("line_sensor_error_tracker verification failed");
		end
		$finish;
	end

endmodule
